>>> rtl/core/wvo_pkg.sv
package wvo_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FRAC_BITS = 22;
    localparam int SEMI_W    = 20;

    localparam int CFG_LEN_W    = 11;
    localparam int CFG_RATE_W   = 18;
    localparam int CFG_ATTACK_W = 20;
    localparam int CFG_DECAY_W  = 16;

    localparam logic [CFG_LEN_W-1:0]    TABLE_LENGTH_RST  = 11'd40;
    localparam logic [CFG_RATE_W-1:0]   SAMPLE_RATE_RST   = 18'd44100;
    localparam logic [CFG_ATTACK_W-1:0] ATTACK_LENGTH_RST = 20'd882;
    localparam logic [CFG_DECAY_W-1:0]  DECAY_FACTOR_RST  = 16'd65493;

    typedef enum logic [1:0] {
        REG_TABLE_LENGTH  = 2'd0,
        REG_SAMPLE_RATE   = 2'd1,
        REG_ATTACK_LENGTH = 2'd2,
        REG_DECAY_FACTOR  = 2'd3
    } reg_addr_t;

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_NOTE_ON  = 3'd1,
        KIND_NOTE_OFF = 3'd2,
        KIND_END      = 3'd3,
        KIND_WRITE    = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SILENT,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_RD_A,
        ST_RD_B,
        ST_MUL_I,
        ST_INTERP,
        ST_MUL_G,
        ST_MUL_S,
        ST_DIV_S,
        ST_DIV_S_WAIT,
        ST_MUL_D,
        ST_FINISH,
        ST_NOTE_MUL,
        ST_NOTE_DIV,
        ST_NOTE_WAIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_NOTE,
        MUL_INTERP,
        MUL_GAIN,
        MUL_SCALE,
        MUL_DECAY
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_NOTE,
        DIV_MOD,
        DIV_SCALE
    } div_op_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_NOTE_OFF,
        ACT_END,
        ACT_WRITE
    } act_t;

    typedef enum logic [1:0] {
        ADDR_WR,
        ADDR_I0,
        ADDR_I1
    } ram_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_op_t  mul_op;
        logic     div_start;
        div_op_t  div_op;
        act_t     act;
        ram_sel_t ram_sel;
        logic     fold_ld;
        logic     a_ld;
        logic     interp_ld;
        logic     sat_ld;
        logic     note_ld;
        logic     silent_out;
        logic     tick_out;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  sounding;
        logic  div_busy;
        logic  out_free;
    } sts_t;

    function automatic logic [SEMI_W-1:0] semitone_q16(input logic [3:0] r);
        logic [SEMI_W-1:0] f;
        case (r)
            4'd0:    f = 20'd535809;
            4'd1:    f = 20'd567670;
            4'd2:    f = 20'd601425;
            4'd3:    f = 20'd637188;
            4'd4:    f = 20'd675077;
            4'd5:    f = 20'd715219;
            4'd6:    f = 20'd757749;
            4'd7:    f = 20'd802807;
            4'd8:    f = 20'd850544;
            4'd9:    f = 20'd901120;
            4'd10:   f = 20'd954703;
            4'd11:   f = 20'd1011473;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

>>> rtl/core/wvo_ram.sv
module wvo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/wvo_ctrl.sv
module wvo_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  wvo_pkg::sts_t sts,
    output wvo_pkg::cmd_t cmd
);

    wvo_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wvo_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wvo_pkg::ST_IDLE: begin
                if (s_valid) state_next = wvo_pkg::ST_DECODE;
            end
            wvo_pkg::ST_DECODE: begin
                unique case (sts.kind)
                    wvo_pkg::KIND_TICK:
                        state_next = sts.sounding ? wvo_pkg::ST_MOD_GO : wvo_pkg::ST_SILENT;
                    wvo_pkg::KIND_NOTE_ON: state_next = wvo_pkg::ST_NOTE_MUL;
                    default:               state_next = wvo_pkg::ST_IDLE;
                endcase
            end
            wvo_pkg::ST_SILENT: begin
                if (sts.out_free) state_next = wvo_pkg::ST_IDLE;
            end
            wvo_pkg::ST_MOD_GO:   state_next = wvo_pkg::ST_MOD_WAIT;
            wvo_pkg::ST_MOD_WAIT: begin
                if (!sts.div_busy) state_next = wvo_pkg::ST_RD_A;
            end
            wvo_pkg::ST_RD_A:   state_next = wvo_pkg::ST_RD_B;
            wvo_pkg::ST_RD_B:   state_next = wvo_pkg::ST_MUL_I;
            wvo_pkg::ST_MUL_I:  state_next = wvo_pkg::ST_INTERP;
            wvo_pkg::ST_INTERP: state_next = wvo_pkg::ST_MUL_G;
            wvo_pkg::ST_MUL_G:  state_next = wvo_pkg::ST_MUL_S;
            wvo_pkg::ST_MUL_S:  state_next = wvo_pkg::ST_DIV_S;
            wvo_pkg::ST_DIV_S:  state_next = wvo_pkg::ST_DIV_S_WAIT;
            wvo_pkg::ST_DIV_S_WAIT: begin
                if (!sts.div_busy) state_next = wvo_pkg::ST_MUL_D;
            end
            wvo_pkg::ST_MUL_D:  state_next = wvo_pkg::ST_FINISH;
            wvo_pkg::ST_FINISH: begin
                if (sts.out_free) state_next = wvo_pkg::ST_IDLE;
            end
            wvo_pkg::ST_NOTE_MUL: state_next = wvo_pkg::ST_NOTE_DIV;
            wvo_pkg::ST_NOTE_DIV: state_next = wvo_pkg::ST_NOTE_WAIT;
            wvo_pkg::ST_NOTE_WAIT: begin
                if (!sts.div_busy) state_next = wvo_pkg::ST_IDLE;
            end
            default: state_next = wvo_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_op  = wvo_pkg::MUL_NONE;
        cmd.div_op  = wvo_pkg::DIV_NOTE;
        cmd.act     = wvo_pkg::ACT_NONE;
        cmd.ram_sel = wvo_pkg::ADDR_WR;
        s_ready     = 1'b0;
        unique case (state_reg)
            wvo_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            wvo_pkg::ST_DECODE: begin
                unique case (sts.kind)
                    wvo_pkg::KIND_NOTE_OFF: cmd.act = wvo_pkg::ACT_NOTE_OFF;
                    wvo_pkg::KIND_END:      cmd.act = wvo_pkg::ACT_END;
                    wvo_pkg::KIND_WRITE:    cmd.act = wvo_pkg::ACT_WRITE;
                    default:                cmd.act = wvo_pkg::ACT_NONE;
                endcase
            end
            wvo_pkg::ST_SILENT: cmd.silent_out = sts.out_free;
            wvo_pkg::ST_MOD_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = wvo_pkg::DIV_MOD;
            end
            wvo_pkg::ST_MOD_WAIT: cmd.fold_ld = !sts.div_busy;
            wvo_pkg::ST_RD_A:     cmd.ram_sel = wvo_pkg::ADDR_I0;
            wvo_pkg::ST_RD_B: begin
                cmd.ram_sel = wvo_pkg::ADDR_I1;
                cmd.a_ld    = 1'b1;
            end
            wvo_pkg::ST_MUL_I: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = wvo_pkg::MUL_INTERP;
            end
            wvo_pkg::ST_INTERP: cmd.interp_ld = 1'b1;
            wvo_pkg::ST_MUL_G: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = wvo_pkg::MUL_GAIN;
            end
            wvo_pkg::ST_MUL_S: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = wvo_pkg::MUL_SCALE;
            end
            wvo_pkg::ST_DIV_S: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = wvo_pkg::DIV_SCALE;
            end
            wvo_pkg::ST_DIV_S_WAIT: cmd.sat_ld = !sts.div_busy;
            wvo_pkg::ST_MUL_D: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = wvo_pkg::MUL_DECAY;
            end
            wvo_pkg::ST_FINISH: cmd.tick_out = sts.out_free;
            wvo_pkg::ST_NOTE_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = wvo_pkg::MUL_NOTE;
            end
            wvo_pkg::ST_NOTE_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = wvo_pkg::DIV_NOTE;
            end
            wvo_pkg::ST_NOTE_WAIT: cmd.note_ld = !sts.div_busy;
            default: ;
        endcase
    end

endmodule

>>> rtl/core/wvo_dp.sv
module wvo_dp #(
    parameter int TABLE_DEPTH = wvo_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = wvo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wvo_pkg::cmd_t                       cmd,
    output wvo_pkg::sts_t                       sts,
    input  logic [2:0]                          s_kind,
    input  logic [6:0]                          s_note,
    input  logic [7:0]                          s_velocity,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      s_table_index,
    input  logic signed [SAMPLE_BITS-1:0]       s_table_value,
    input  logic [wvo_pkg::CFG_LEN_W-1:0]       cfg_table_length,
    input  logic [wvo_pkg::CFG_RATE_W-1:0]      cfg_sample_rate,
    input  logic [wvo_pkg::CFG_ATTACK_W-1:0]    cfg_attack_length,
    input  logic [wvo_pkg::CFG_DECAY_W-1:0]     cfg_decay_factor,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_sample,
    output logic                                m_release_request,
    output logic                                m_voice_active
);

    localparam int FB    = wvo_pkg::FRAC_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int LEN_W = (IDX_W + 1 > wvo_pkg::CFG_LEN_W) ? IDX_W + 1 : wvo_pkg::CFG_LEN_W;
    localparam int PH_W  = ((LEN_W + FB > 32) ? LEN_W + FB : 32) + 1;
    localparam int IW    = PH_W - FB;
    localparam int NUM_W = LEN_W + wvo_pkg::SEMI_W + 16;
    localparam int DV_W  = NUM_W;
    localparam int DS_W  = (LEN_W > wvo_pkg::CFG_RATE_W) ? LEN_W : wvo_pkg::CFG_RATE_W;
    localparam int MA_W  = (SB + 8 > LEN_W + 1) ? SB + 8 : LEN_W + 1;
    localparam int MB_W  = FB + 1;
    localparam int P_W   = MA_W + MB_W;
    localparam int CNT_W = $clog2(DV_W + 1);
    localparam int MAG_W = SB + 8;
    localparam int AW    = wvo_pkg::CFG_ATTACK_W;
    localparam int RK    = MAG_W + 7;

    localparam logic [LEN_W-1:0]        DEPTH_L  = LEN_W'(TABLE_DEPTH);
    localparam logic signed [P_W-1:0]   RND      = P_W'((64'd1 << FB) - 64'd1);
    localparam logic [MAG_W-1:0]        SAT_MAX  = MAG_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [MAG_W:0]          RCP127   =
        (MAG_W + 1)'(((64'd1 << RK) + 64'd126) / 64'd127);

    // latched item
    wvo_pkg::kind_t         kind_reg;
    logic [6:0]             note_reg;
    logic [7:0]             vel_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic signed [SB-1:0]   val_reg;

    // voice state
    logic [PH_W-1:0]        phase_reg;
    logic [31:0]            step_reg;
    logic [6:0]             gain_reg;
    logic [15:0]            decay_reg;
    logic [AW-1:0]          acnt_reg;
    logic                   adone_reg, released_reg, pend_reg, sounding_reg;

    // work registers
    logic signed [P_W-1:0]  p_reg;
    logic signed [SB-1:0]   a_reg;
    logic signed [SB-1:0]   interp_reg;
    logic                   sign_reg;
    logic signed [SB-1:0]   smp_reg;

    // divider
    logic [DV_W-1:0]        dq_reg;
    logic [DS_W-1:0]        rem_reg;
    logic [DS_W-1:0]        dvs_reg;
    logic [CNT_W-1:0]       cnt_reg;

    // outputs
    logic                   m_valid_reg;
    logic signed [SB-1:0]   m_sample_reg;
    logic                   m_req_reg, m_act_reg;

    logic                   out_free;
    logic [LEN_W-1:0]       len;
    logic [12:0]            nq;
    logic [3:0]             n_div12;
    logic [6:0]             n_mod12;
    logic [4:0]             nsh;
    logic [16:0]            scale;
    logic [IDX_W-1:0]       i0, i1;
    logic [LEN_W-1:0]       i0_inc;
    logic [FB-1:0]          frac;
    logic [SB-1:0]          rdata;
    logic [IDX_W-1:0]       ram_addr;
    logic                   ram_we;
    logic signed [SB:0]     diff;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod;
    logic signed [P_W-1:0]  a_sh, isum, iadj, ishift;
    logic [P_W-1:0]         pmag;
    logic [MAG_W-1:0]       mag_sh;
    logic [DS_W:0]          trial;
    logic                   qbit;
    logic [2*MAG_W:0]       qprod;
    logic [MAG_W-1:0]       qv, qneg;
    logic [AW-1:0]          acnt_nx;
    logic                   ahit;
    logic [DS_W-1:0]        rate_div;

    assign len = (cfg_table_length == '0) ? LEN_W'(1) :
                 (LEN_W'(cfg_table_length) > DEPTH_L) ? DEPTH_L : LEN_W'(cfg_table_length);

    // note / 12 by reciprocal, exact for 7-bit notes
    assign nq      = 13'(note_reg) * 13'd43;
    assign n_div12 = nq[12:9];
    assign n_mod12 = note_reg - 7'(n_div12) * 7'd12;
    assign nsh     = 5'(n_div12) + 5'd6;

    assign scale = (released_reg && decay_reg != 16'hFFFF) ? {1'b0, decay_reg} : 17'h10000;

    assign frac   = phase_reg[FB-1:0];
    assign i0     = phase_reg[FB +: IDX_W];
    assign i0_inc = LEN_W'(i0) + LEN_W'(1);
    assign i1     = (i0_inc < len) ? i0_inc[IDX_W-1:0] : '0;

    always_comb begin
        case (cmd.ram_sel)
            wvo_pkg::ADDR_I0: ram_addr = i0;
            wvo_pkg::ADDR_I1: ram_addr = i1;
            default:          ram_addr = idx_reg;
        endcase
    end
    assign ram_we = (cmd.act == wvo_pkg::ACT_WRITE) &&
                    ({1'b0, idx_reg} < (IDX_W + 1)'(TABLE_DEPTH));

    wvo_ram #(.WIDTH(SB), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (rdata)
    );

    // shared multiplier
    assign diff = $signed({rdata[SB-1], rdata}) - $signed({a_reg[SB-1], a_reg});
    always_comb begin
        case (cmd.mul_op)
            wvo_pkg::MUL_NOTE: begin
                mul_a = $signed(MA_W'(len));
                mul_b = $signed(MB_W'(wvo_pkg::semitone_q16(n_mod12[3:0])));
            end
            wvo_pkg::MUL_INTERP: begin
                mul_a = MA_W'(diff);
                mul_b = $signed(MB_W'(frac));
            end
            wvo_pkg::MUL_GAIN: begin
                mul_a = MA_W'(interp_reg);
                mul_b = $signed(MB_W'(gain_reg));
            end
            wvo_pkg::MUL_SCALE: begin
                mul_a = MA_W'(p_reg);
                mul_b = $signed(MB_W'(scale));
            end
            wvo_pkg::MUL_DECAY: begin
                mul_a = $signed(MA_W'(scale));
                mul_b = $signed(MB_W'(cfg_decay_factor));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = P_W'(mul_a) * P_W'(mul_b);

    // interpolation, truncated toward zero
    assign a_sh   = P_W'(a_reg) <<< FB;
    assign isum   = a_sh + p_reg;
    assign iadj   = isum[P_W-1] ? isum + RND : isum;
    assign ishift = iadj >>> FB;

    assign pmag   = p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
    assign mag_sh = pmag[16 +: MAG_W];

    assign rate_div = (cfg_sample_rate == '0) ? DS_W'(1) : DS_W'(cfg_sample_rate);

    // restoring divider step
    assign trial = {rem_reg, dq_reg[DV_W-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    // magnitude / 127 by reciprocal multiply, exact over the magnitude width
    assign qprod = (2 * MAG_W + 1)'(dq_reg[MAG_W-1:0]) * (2 * MAG_W + 1)'(RCP127);
    assign qv    = MAG_W'(qprod[2*MAG_W:RK]);
    assign qneg  = -qv;

    assign acnt_nx = (acnt_reg != {AW{1'b1}}) ? acnt_reg + AW'(1) : acnt_reg;
    assign ahit    = !adone_reg && (acnt_nx >= cfg_attack_length);

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= wvo_pkg::kind_t'(s_kind);
            note_reg <= s_note;
            vel_reg  <= s_velocity;
            idx_reg  <= s_table_index;
            val_reg  <= s_table_value;
        end
        if (cmd.mul_en)    p_reg      <= prod;
        if (cmd.a_ld)      a_reg      <= $signed(rdata);
        if (cmd.interp_ld) interp_reg <= ishift[SB-1:0];
        if (cmd.sat_ld) begin
            if (!sign_reg) smp_reg <= (qv > SAT_MAX) ? SB'(SAT_MAX) : SB'(qv);
            else           smp_reg <= qneg[SB-1:0];
        end
        if (cmd.silent_out) begin
            m_sample_reg <= '0;
            m_req_reg    <= 1'b0;
            m_act_reg    <= 1'b0;
        end else if (cmd.tick_out) begin
            m_sample_reg <= smp_reg;
            m_req_reg    <= pend_reg || ahit;
            m_act_reg    <= 1'b1;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            case (cmd.div_op)
                wvo_pkg::DIV_MOD: begin
                    dq_reg  <= {phase_reg[PH_W-1:FB], (DV_W - IW)'(0)};
                    dvs_reg <= DS_W'(len);
                end
                wvo_pkg::DIV_SCALE: begin
                    dq_reg   <= DV_W'(mag_sh);
                    sign_reg <= p_reg[P_W-1];
                end
                default: begin
                    dq_reg  <= DV_W'(p_reg[LEN_W + wvo_pkg::SEMI_W - 1:0]) << nsh;
                    dvs_reg <= rate_div;
                end
            endcase
        end else if (cnt_reg != '0) begin
            rem_reg <= qbit ? DS_W'(trial - {1'b0, dvs_reg}) : trial[DS_W-1:0];
            dq_reg  <= {dq_reg[DV_W-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= '0;
            step_reg     <= '0;
            gain_reg     <= '0;
            decay_reg    <= 16'hFFFF;
            acnt_reg     <= '0;
            adone_reg    <= 1'b0;
            released_reg <= 1'b0;
            pend_reg     <= 1'b0;
            sounding_reg <= 1'b0;
        end else begin
            if (cmd.div_start) begin
                case (cmd.div_op)
                    wvo_pkg::DIV_MOD:   cnt_reg <= CNT_W'(IW);
                    wvo_pkg::DIV_SCALE: cnt_reg <= '0;
                    default:            cnt_reg <= CNT_W'(DV_W);
                endcase
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (cmd.silent_out || cmd.tick_out) m_valid_reg <= 1'b1;
            else if (m_ready)                   m_valid_reg <= 1'b0;

            if (cmd.fold_ld) begin
                phase_reg <= PH_W'({rem_reg[LEN_W-1:0], phase_reg[FB-1:0]});
            end

            case (cmd.act)
                wvo_pkg::ACT_NOTE_OFF: begin
                    if (sounding_reg) begin
                        released_reg <= 1'b1;
                        decay_reg    <= 16'hFFFF;
                        pend_reg     <= 1'b1;
                    end
                end
                wvo_pkg::ACT_END: begin
                    sounding_reg <= 1'b0;
                    pend_reg     <= 1'b0;
                end
                default: ;
            endcase

            if (cmd.note_ld) begin
                step_reg     <= (|dq_reg[DV_W-1:32]) ? 32'hFFFF_FFFF : dq_reg[31:0];
                phase_reg    <= '0;
                gain_reg     <= vel_reg[7] ? 7'd127 : vel_reg[6:0];
                decay_reg    <= 16'hFFFF;
                acnt_reg     <= '0;
                adone_reg    <= 1'b0;
                released_reg <= 1'b0;
                pend_reg     <= 1'b0;
                sounding_reg <= 1'b1;
            end

            if (cmd.tick_out) begin
                if (released_reg) decay_reg <= p_reg[31:16];
                pend_reg <= 1'b0;
                if (!adone_reg) begin
                    acnt_reg <= acnt_nx;
                    if (ahit) adone_reg <= 1'b1;
                end
                phase_reg <= phase_reg + PH_W'(step_reg);
            end
        end
    end

    assign sts.kind     = kind_reg;
    assign sts.sounding = sounding_reg;
    assign sts.div_busy = (cnt_reg != '0);
    assign sts.out_free = out_free;

    assign m_valid           = m_valid_reg;
    assign m_sample          = m_sample_reg;
    assign m_release_request = m_req_reg;
    assign m_voice_active    = m_act_reg;

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_start && cmd.div_op != wvo_pkg::DIV_SCALE) |=> (cnt_reg != '0))
        else $error("divider did not start");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.silent_out || cmd.tick_out) |-> out_free)
        else $error("result loaded over a waiting item");

    a_pend_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        !sounding_reg |-> !pend_reg)
        else $error("release pending on a silent voice");

    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fold_ld |=> (phase_reg[PH_W-1:FB] < PH_W'(len)))
        else $error("phase not reduced below table length");

endmodule

>>> rtl/core/wavetable_voice_oscillator.sv
// Channel  Ports                                         Direction
// s_       s_valid/s_ready, kind note velocity index val  in
// m_       m_valid/m_ready, sample release active         out
// apb      psel penable pwrite paddr pwdata prdata pready config
//
// Tick: the serial divider does the phase wrap one bit a cycle; gain scaling
//   divides by 127 with a reciprocal multiply.
// Note on: runs the serial divider on table_length * f / sample_rate.
// Synchronous active-low reset, no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile.
module wavetable_voice_oscillator #(
    parameter int TABLE_DEPTH = wvo_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = wvo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_kind,
    input  logic [6:0]                     s_note,
    input  logic [7:0]                     s_velocity,
    input  logic [$clog2(TABLE_DEPTH)-1:0] s_table_index,
    input  logic signed [SAMPLE_BITS-1:0]  s_table_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_sample,
    output logic                           m_release_request,
    output logic                           m_voice_active,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [wvo_pkg::CFG_LEN_W-1:0]    tlen_reg;
    logic [wvo_pkg::CFG_RATE_W-1:0]   rate_reg;
    logic [wvo_pkg::CFG_ATTACK_W-1:0] attack_reg;
    logic [wvo_pkg::CFG_DECAY_W-1:0]  decay_reg;
    logic                             wr;
    wvo_pkg::cmd_t                    cmd;
    wvo_pkg::sts_t                    sts;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlen_reg   <= wvo_pkg::TABLE_LENGTH_RST;
            rate_reg   <= wvo_pkg::SAMPLE_RATE_RST;
            attack_reg <= wvo_pkg::ATTACK_LENGTH_RST;
            decay_reg  <= wvo_pkg::DECAY_FACTOR_RST;
        end else if (wr) begin
            unique case (wvo_pkg::reg_addr_t'(paddr[3:2]))
                wvo_pkg::REG_TABLE_LENGTH:  tlen_reg   <= pwdata[wvo_pkg::CFG_LEN_W-1:0];
                wvo_pkg::REG_SAMPLE_RATE:   rate_reg   <= pwdata[wvo_pkg::CFG_RATE_W-1:0];
                wvo_pkg::REG_ATTACK_LENGTH: attack_reg <= pwdata[wvo_pkg::CFG_ATTACK_W-1:0];
                wvo_pkg::REG_DECAY_FACTOR:  decay_reg  <= pwdata[wvo_pkg::CFG_DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (wvo_pkg::reg_addr_t'(paddr[3:2]))
            wvo_pkg::REG_TABLE_LENGTH:  prdata = 32'(tlen_reg);
            wvo_pkg::REG_SAMPLE_RATE:   prdata = 32'(rate_reg);
            wvo_pkg::REG_ATTACK_LENGTH: prdata = 32'(attack_reg);
            wvo_pkg::REG_DECAY_FACTOR:  prdata = 32'(decay_reg);
            default:                    prdata = '0;
        endcase
    end

    wvo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wvo_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_kind            (s_kind),
        .s_note            (s_note),
        .s_velocity        (s_velocity),
        .s_table_index     (s_table_index),
        .s_table_value     (s_table_value),
        .cfg_table_length  (tlen_reg),
        .cfg_sample_rate   (rate_reg),
        .cfg_attack_length (attack_reg),
        .cfg_decay_factor  (decay_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sample          (m_sample),
        .m_release_request (m_release_request),
        .m_voice_active    (m_voice_active)
    );

endmodule

>>> verif/tb_wavetable_voice_oscillator.sv
module tb_wavetable_voice_oscillator;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_kind = '0;
    logic [6:0]  s_note = '0;
    logic [7:0]  s_velocity = '0;
    logic [9:0]  s_table_index = '0;
    logic signed [15:0] s_table_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_sample;
    logic        m_release_request;
    logic        m_voice_active;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    wavetable_voice_oscillator uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("tb_wavetable_voice_oscillator: FAIL");
        $finish;
    end

    typedef struct packed {
        logic signed [15:0] sample;
        logic               rel;
        logic               active;
    } voice_out_t;

    voice_out_t samples_due[$];
    int errors = 0;

    // predictor state
    logic [10:0] cfg_len;
    logic [17:0] cfg_rate;
    logic [19:0] cfg_attack;
    logic [15:0] cfg_decay;
    logic signed [15:0] tbl [0:1023];
    logic [63:0] ph;
    logic [31:0] ph_step;
    int unsigned gain, dgain, att_cnt;
    bit att_done, rel_flag, rel_pend, sounding;
    int unsigned semi [12] = '{535809, 567670, 601425, 637188, 675077, 715219,
                               757749, 802807, 850544, 901120, 954703, 1011473};

    function automatic longint unsigned used_len();
        longint unsigned l;
        l = cfg_len;
        if (l < 1) l = 1;
        if (l > 1024) l = 1024;
        return l;
    endfunction

    task automatic predict_voice(input logic [2:0] k, input logic [6:0] nt,
                                 input logic [7:0] vel, input logic [9:0] idx,
                                 input logic signed [15:0] val);
        longint unsigned l, freq, rate, stp, frac, scl;
        longint a, b, interp, v;
        int unsigned i0, i1;
        voice_out_t r;
        case (k)
            wvo_pkg::KIND_NOTE_ON: begin
                freq = longint'(semi[nt % 12]) << (nt / 12);
                rate = cfg_rate == 0 ? 1 : cfg_rate;
                stp = ((used_len() * freq) << 6) / rate;
                ph_step = stp > 64'hFFFFFFFF ? 32'hFFFFFFFF : stp[31:0];
                ph = 0;
                gain = vel > 127 ? 127 : vel;
                dgain = 16'hFFFF;
                att_cnt = 0;
                att_done = 0; rel_flag = 0; rel_pend = 0; sounding = 1;
            end
            wvo_pkg::KIND_NOTE_OFF: if (sounding) begin
                rel_flag = 1; dgain = 16'hFFFF; rel_pend = 1;
            end
            wvo_pkg::KIND_END: begin
                sounding = 0; rel_pend = 0;
            end
            wvo_pkg::KIND_WRITE: begin
                tbl[idx] = val;
            end
            wvo_pkg::KIND_TICK: begin
                r = '0;
                if (sounding) begin
                    l = used_len();
                    ph = ph % (l << 22);
                    i0 = 32'(ph >> 22);
                    frac = ph & 64'h3FFFFF;
                    i1 = (i0 + 1 < l) ? i0 + 1 : 0;
                    a = tbl[i0];
                    b = tbl[i1];
                    interp = (a * longint'((64'd1 << 22) - frac) + b * longint'(frac))
                             / (64'sd1 <<< 22);
                    scl = 65536;
                    if (rel_flag && dgain != 16'hFFFF) scl = dgain;
                    v = interp * longint'(gain) * longint'(scl) / (64'sd127 * 64'sd65536);
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                    if (rel_flag) dgain = 32'((scl * cfg_decay) >> 16);
                    r.sample = v[15:0];
                    if (rel_pend) begin
                        r.rel = 1; rel_pend = 0;
                    end
                    if (!att_done) begin
                        if (att_cnt < 20'hFFFFF) att_cnt++;
                        if (att_cnt >= cfg_attack) begin
                            att_done = 1; r.rel = 1;
                        end
                    end
                    ph = ph + ph_step;
                    r.active = 1;
                end
                samples_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    // sender burst control
    int burst_left = 0;

    task automatic send_item(input logic [2:0] k, input logic [6:0] nt = 0,
                             input logic [7:0] vel = 0, input logic [9:0] idx = 0,
                             input logic signed [15:0] val = 0);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_kind <= k;
        s_note <= nt;
        s_velocity <= vel;
        s_table_index <= idx;
        s_table_value <= val;
        do @(posedge aclk); while (!s_ready);
        predict_voice(k, nt, vel, idx, val);
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_valid <= 1'b0;
        while (samples_due.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(input wvo_pkg::reg_addr_t r, input logic [31:0] d);
        s_valid <= 1'b0;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {r, 2'b00}; pwdata <= d;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            wvo_pkg::REG_TABLE_LENGTH:  cfg_len = d[10:0];
            wvo_pkg::REG_SAMPLE_RATE:   cfg_rate = d[17:0];
            wvo_pkg::REG_ATTACK_LENGTH: cfg_attack = d[19:0];
            wvo_pkg::REG_DECAY_FACTOR:  cfg_decay = d[15:0];
            default: ;
        endcase
    endtask

    // receiver: by mode, never stalls, stalls on a rotating pattern, or stalls at random
    logic [15:0] stall_pat = 16'b1011_0001_1111_0100;
    int stall_mode = 0;
    always @(posedge aclk) begin
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= stall_pat[0];
            default: m_ready <= $urandom_range(0, 3) != 0;
        endcase
    end

    always @(posedge aclk) begin
        voice_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected result sample=%0d", $time, m_sample);
                errors++;
            end else begin
                e = samples_due.pop_front();
                if (m_sample !== e.sample) begin
                    $display("%0t: sample exp %0d got %0d", $time, e.sample, m_sample);
                    errors++;
                end
                if (m_release_request !== e.rel) begin
                    $display("%0t: release_request exp %0b got %0b", $time, e.rel,
                             m_release_request);
                    errors++;
                end
                if (m_voice_active !== e.active) begin
                    $display("%0t: voice_active exp %0b got %0b", $time, e.active,
                             m_voice_active);
                    errors++;
                end
            end
        end
    end

    // fills entries 0..n-1 so every read of a table of length up to n hits a written entry
    task automatic load_table(input int n, input bit extremes);
        logic signed [15:0] w;
        for (int i = 0; i < n; i++) begin
            w = 16'($urandom);
            if (extremes) w = (i % 2) ? 16'sh7FFF : 16'sh8000;
            send_item(wvo_pkg::KIND_WRITE, 7'($urandom), 8'($urandom), i[9:0], w);
        end
    endtask

    task automatic test_directed();
        write_reg(wvo_pkg::REG_TABLE_LENGTH, 4);
        write_reg(wvo_pkg::REG_SAMPLE_RATE, 8000);
        write_reg(wvo_pkg::REG_ATTACK_LENGTH, 3);
        write_reg(wvo_pkg::REG_DECAY_FACTOR, 16'hFFFF);
        send_item(wvo_pkg::KIND_TICK);
        send_item(wvo_pkg::KIND_NOTE_OFF);
        send_item(wvo_pkg::KIND_WRITE, 0, 0, 10'h3FF, 16'sh7FFF);
        load_table(4, 1);
        send_item(wvo_pkg::KIND_NOTE_ON, 127, 255);
        repeat (3) send_item(wvo_pkg::KIND_TICK);
        send_item(wvo_pkg::KIND_NOTE_ON, 0, 0);
        send_item(wvo_pkg::KIND_TICK);
        send_item(wvo_pkg::KIND_NOTE_ON, 69, 127);
        send_item(wvo_pkg::KIND_TICK);
        send_item(wvo_pkg::KIND_NOTE_OFF);
        repeat (3) send_item(wvo_pkg::KIND_TICK);
        send_item(3'd5); send_item(3'd7);
        send_item(wvo_pkg::KIND_END);
        send_item(wvo_pkg::KIND_TICK);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(wvo_pkg::REG_TABLE_LENGTH, 1);
        write_reg(wvo_pkg::REG_SAMPLE_RATE, 192000);
        write_reg(wvo_pkg::REG_ATTACK_LENGTH, 0);
        write_reg(wvo_pkg::REG_DECAY_FACTOR, 0);
        send_item(wvo_pkg::KIND_NOTE_ON, 60, 100);
        repeat (2) send_item(wvo_pkg::KIND_TICK);
        send_item(wvo_pkg::KIND_NOTE_OFF);
        repeat (3) send_item(wvo_pkg::KIND_TICK);
        drain();
        write_reg(wvo_pkg::REG_TABLE_LENGTH, 1024);
        write_reg(wvo_pkg::REG_SAMPLE_RATE, 0);
        write_reg(wvo_pkg::REG_ATTACK_LENGTH, 32'hFFFFF);
        // saturated step only visits the first two entries and the last one
        send_item(wvo_pkg::KIND_WRITE, 0, 0, 10'd0, 16'($urandom));
        send_item(wvo_pkg::KIND_WRITE, 0, 0, 10'd1, 16'($urandom));
        send_item(wvo_pkg::KIND_WRITE, 0, 0, 10'h3FF, 16'($urandom));
        send_item(wvo_pkg::KIND_NOTE_ON, 127, 200);
        repeat (4) send_item(wvo_pkg::KIND_TICK);
        drain();
    endtask

    task automatic test_random_voices(input int phases);
        int n;
        for (int p = 0; p < phases; p++) begin
            n = $urandom_range(2, 48);
            write_reg(wvo_pkg::REG_TABLE_LENGTH, n);
            write_reg(wvo_pkg::REG_SAMPLE_RATE, $urandom_range(8000, 192000));
            write_reg(wvo_pkg::REG_ATTACK_LENGTH, $urandom_range(0, 12));
            write_reg(wvo_pkg::REG_DECAY_FACTOR, $urandom_range(0, 3) == 0 ? $urandom :
                      $urandom_range(60000, 65535));
            for (int i = 0; i < 50; i++) begin
                case ($urandom_range(0, 19))
                    0, 1: send_item(wvo_pkg::KIND_NOTE_ON, 7'($urandom), 8'($urandom));
                    2: send_item(wvo_pkg::KIND_NOTE_OFF);
                    3: send_item(wvo_pkg::KIND_END);
                    4: send_item(wvo_pkg::KIND_WRITE, 7'($urandom), 8'($urandom),
                                 10'($urandom_range(0, n - 1)), 16'($urandom));
                    5: send_item(3'($urandom_range(5, 7)));
                    default: send_item(wvo_pkg::KIND_TICK);
                endcase
            end
            drain();
        end
    endtask

    initial begin
        cfg_len = wvo_pkg::TABLE_LENGTH_RST;
        cfg_rate = wvo_pkg::SAMPLE_RATE_RST;
        cfg_attack = wvo_pkg::ATTACK_LENGTH_RST;
        cfg_decay = wvo_pkg::DECAY_FACTOR_RST;
        ph = 0; ph_step = 0; gain = 0; dgain = 16'hFFFF; att_cnt = 0;
        att_done = 0; rel_flag = 0; rel_pend = 0; sounding = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        load_table(48, 0);
        test_random_voices(8);
        drain();
        if (errors == 0 && samples_due.size() == 0)
            $display("tb_wavetable_voice_oscillator: PASS");
        else
            $display("tb_wavetable_voice_oscillator: FAIL");
        $finish;
    end
endmodule
